FILE: rtl/pixel_point_op_engine_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pixel point-operation engine
// Clocked property checks with an active-low reset guard.
// ----------------------------------------------------------------------------
`ifndef PIXEL_POINT_OP_ENGINE_TOP_ASSERT_SVH
`define PIXEL_POINT_OP_ENGINE_TOP_ASSERT_SVH

// Property must hold at every rising edge outside reset.
`define PPOE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Expression must never be true outside reset.
`define PPOE_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    `PPOE_ASSERT(lbl, clk, rstn, !(expr), msg)

`endif

FILE: rtl/ppoe_pkg.sv
// ----------------------------------------------------------------------------
// ppoe_pkg
// Shared widths, codes, command/status types and pixel helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppoe_pkg;

    localparam int PIX_W   = 8;
    localparam int DATA_W  = 4 * PIX_W;
    localparam int CFG_IDX_W = 3;
    localparam int SUM_W   = 28;
    localparam int CNT_W   = 21;
    localparam int Q_W     = 8;

    localparam logic [CNT_W-1:0] MAX_REGION_PIXELS = CNT_W'(1048576);

    // operation codes
    localparam logic [2:0] OP_GREY   = 3'd0;
    localparam logic [2:0] OP_NEG    = 3'd1;
    localparam logic [2:0] OP_SWITCH = 3'd2;
    localparam logic [2:0] OP_FILL   = 3'd3;
    localparam logic [2:0] OP_BW     = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OPERATION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_RED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_GREEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_BLUE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_RED     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_GREEN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_BLUE    = 3'd7;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef struct packed {
        logic accept;
        logic load_main;
        logic main_from_skid;
        logic load_skid;
        logic div_start;
    } ppoe_cmd_t;

    typedef struct packed {
        logic has_result;
        logic ends_measure;
    } ppoe_status_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
        logic             changed;
        logic             last;
    } ppoe_result_t;

    // floor((r+g+b)/3) as multiply by 683/2048; exact for sums up to 765
    function automatic logic [PIX_W-1:0] grey_of(input logic [PIX_W-1:0] r,
                                                 input logic [PIX_W-1:0] g,
                                                 input logic [PIX_W-1:0] b);
        logic [9:0]  s;
        logic [19:0] p;
        s = {2'b00, r} + {2'b00, g} + {2'b00, b};
        p = {10'd0, s} * 20'd683;
        return p[18:11];
    endfunction

    function automatic logic near_channel(input logic [PIX_W-1:0] c,
                                          input logic [PIX_W-1:0] ref_c,
                                          input logic [PIX_W-1:0] tol);
        logic [PIX_W-1:0] d;
        d = (c >= ref_c) ? (c - ref_c) : (ref_c - c);
        return d <= tol;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ppoe_ctrl.sv
// ----------------------------------------------------------------------------
// ppoe_ctrl
// Handshake and sequencing: output/skid occupancy, mean division wait.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppoe_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire ppoe_pkg::ppoe_status_t status,
    input  wire logic                  div_done,
    output ppoe_pkg::ppoe_cmd_t        cmd
);
    import ppoe_pkg::*;

`include "pixel_point_op_engine_top_assert.svh"

    localparam logic ST_RUN = 1'b0;
    localparam logic ST_DIV = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    logic accept, has_res, pop;

    always_comb begin
        s_tready        = (state_reg == ST_RUN) && !skid_valid_reg;
        accept          = s_tvalid && s_tready;
        has_res         = accept && status.has_result;
        pop             = out_valid_reg && m_tready;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        state_next      = state_reg;
        cmd             = '0;
        cmd.accept      = accept;
        cmd.div_start   = accept && status.ends_measure;

        if (!out_valid_reg) begin
            if (has_res) begin
                cmd.load_main  = 1'b1;
                out_valid_next = 1'b1;
            end
        end else if (pop) begin
            if (skid_valid_reg) begin
                cmd.load_main      = 1'b1;
                cmd.main_from_skid = 1'b1;
                skid_valid_next    = 1'b0;
            end else if (has_res) begin
                cmd.load_main = 1'b1;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (has_res) begin
            cmd.load_skid   = 1'b1;
            skid_valid_next = 1'b1;
        end

        case (state_reg)
            ST_RUN: begin
                if (cmd.div_start) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) state_next = ST_RUN;
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_RUN;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    `PPOE_ASSERT(a_skid_needs_main, aclk, aresetn, skid_valid_reg |-> out_valid_reg,
        "skid entry held without a result in the output register")
    `PPOE_ASSERT(a_div_blocks_input, aclk, aresetn, (state_reg == ST_DIV) |-> !s_tready,
        "input ready while the mean division runs")
    `PPOE_ASSERT(a_start_enters_div, aclk, aresetn, cmd.div_start |=> (state_reg == ST_DIV),
        "division started without entering the wait state")
    `PPOE_ASSERT_NEVER(a_done_only_in_div, aclk, aresetn,
        div_done && (state_reg != ST_DIV), "division done outside the wait state")

endmodule

`default_nettype wire

FILE: rtl/ppoe_div.sv
// ----------------------------------------------------------------------------
// ppoe_div
// Restoring divider for the region mean: 8 quotient bits, one per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppoe_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [ppoe_pkg::SUM_W-1:0]    dividend,
    input  wire logic [ppoe_pkg::CNT_W-1:0]    divisor,
    output logic                               done,
    output logic [ppoe_pkg::Q_W-1:0]           quotient
);
    import ppoe_pkg::*;

    localparam int SH = Q_W - 1;

    logic [SUM_W-1:0] rem_reg;
    logic [SUM_W-1:0] den_reg;
    logic [Q_W-1:0]   q_reg;
    logic [2:0]       step_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             ge;

    // sum <= 255 * count, so the quotient fits in Q_W bits
    assign ge = rem_reg >= den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= busy_reg && (step_reg == 3'd0);
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= 3'(SH);
            end else if (busy_reg) begin
                step_reg <= step_reg - 3'd1;
                if (step_reg == 3'd0) busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            den_reg <= {divisor, {SH{1'b0}}};
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (ge) rem_reg <= rem_reg - den_reg;
            den_reg <= den_reg >> 1;
            q_reg   <= {q_reg[Q_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

FILE: rtl/ppoe_datapath.sv
// ----------------------------------------------------------------------------
// ppoe_datapath
// Config registers, per-pixel operations, mean accumulators, result regs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppoe_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [ppoe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ppoe_pkg::PIX_W-1:0]        cfg_wdata,
    input  wire logic [ppoe_pkg::DATA_W-1:0]       s_tdata,
    input  wire logic                              s_tuser,
    input  wire logic                              s_tlast,
    input  wire ppoe_pkg::ppoe_cmd_t               cmd,
    input  wire logic                              div_done,
    input  wire logic [ppoe_pkg::Q_W-1:0]          div_quot,
    output ppoe_pkg::ppoe_status_t                 status,
    output logic [ppoe_pkg::SUM_W-1:0]             div_dividend,
    output logic [ppoe_pkg::CNT_W-1:0]             div_divisor,
    output logic [ppoe_pkg::DATA_W-1:0]            m_tdata,
    output logic                                   m_tuser,
    output logic                                   m_tlast
);
    import ppoe_pkg::*;

    logic [2:0]       operation_reg;
    logic [PIX_W-1:0] tolerance_reg;
    logic [PIX_W-1:0] match_red_reg, match_green_reg, match_blue_reg;
    logic [PIX_W-1:0] new_red_reg, new_green_reg, new_blue_reg;

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PIX_W-1:0] mean_reg;

    ppoe_result_t main_reg, skid_reg, res;

    logic [PIX_W-1:0] r, g, b, a, grey;
    logic             is_measure, hit;

    assign r    = s_tdata[PIX_W-1:0];
    assign g    = s_tdata[2*PIX_W-1:PIX_W];
    assign b    = s_tdata[3*PIX_W-1:2*PIX_W];
    assign a    = s_tdata[4*PIX_W-1:3*PIX_W];
    assign grey = grey_of(r, g, b);
    assign hit  = near_channel(r, match_red_reg, tolerance_reg) &&
                  near_channel(g, match_green_reg, tolerance_reg) &&
                  near_channel(b, match_blue_reg, tolerance_reg);

    assign is_measure          = (operation_reg == OP_BW) && !s_tuser;
    assign status.has_result   = !is_measure;
    assign status.ends_measure = is_measure && s_tlast;

    always_comb begin
        res      = '{red: r, green: g, blue: b, alpha: a, changed: 1'b1, last: s_tlast};
        case (operation_reg)
            OP_GREY: begin
                res.red   = grey;
                res.green = grey;
                res.blue  = grey;
                res.alpha = PIX_MAX;
            end
            OP_NEG: begin
                res.red   = PIX_MAX - r;
                res.green = PIX_MAX - g;
                res.blue  = PIX_MAX - b;
            end
            OP_SWITCH: begin
                if (hit) begin
                    res.red   = new_red_reg;
                    res.green = new_green_reg;
                    res.blue  = new_blue_reg;
                    res.alpha = PIX_MAX;
                end else begin
                    res.changed = 1'b0;
                end
            end
            OP_FILL: begin
                res.red   = new_red_reg;
                res.green = new_green_reg;
                res.blue  = new_blue_reg;
                res.alpha = PIX_MAX;
            end
            OP_BW: begin
                res.red   = (grey <= mean_reg) ? '0 : PIX_MAX;
                res.green = res.red;
                res.blue  = res.red;
                res.alpha = PIX_MAX;
            end
            default: res.changed = 1'b0;
        endcase
    end

    // accumulate the measuring pass; region capped at MAX_REGION_PIXELS
    always_comb begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (cnt_reg < MAX_REGION_PIXELS) begin
            sum_next = sum_reg + {{(SUM_W-PIX_W){1'b0}}, grey};
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    assign div_dividend = sum_next;
    assign div_divisor  = cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            operation_reg   <= OP_GREY;
            tolerance_reg   <= '0;
            match_red_reg   <= '0;
            match_green_reg <= '0;
            match_blue_reg  <= '0;
            new_red_reg     <= '0;
            new_green_reg   <= '0;
            new_blue_reg    <= '0;
            sum_reg         <= '0;
            cnt_reg         <= '0;
            mean_reg        <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_OPERATION:   operation_reg   <= cfg_wdata[2:0];
                    CFG_TOLERANCE:   tolerance_reg   <= cfg_wdata;
                    CFG_MATCH_RED:   match_red_reg   <= cfg_wdata;
                    CFG_MATCH_GREEN: match_green_reg <= cfg_wdata;
                    CFG_MATCH_BLUE:  match_blue_reg  <= cfg_wdata;
                    CFG_NEW_RED:     new_red_reg     <= cfg_wdata;
                    CFG_NEW_GREEN:   new_green_reg   <= cfg_wdata;
                    CFG_NEW_BLUE:    new_blue_reg    <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.accept && is_measure) begin
                if (s_tlast) begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end else begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_next;
                end
            end
            if (div_done) mean_reg <= div_quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_main) main_reg <= cmd.main_from_skid ? skid_reg : res;
        if (cmd.load_skid) skid_reg <= res;
    end

    assign m_tdata = {main_reg.alpha, main_reg.blue, main_reg.green, main_reg.red};
    assign m_tuser = main_reg.changed;
    assign m_tlast = main_reg.last;

endmodule

`default_nettype wire

FILE: rtl/pixel_point_op_engine_top.sv
// ----------------------------------------------------------------------------
// pixel_point_op_engine_top
// RGBA point operations: grey, negative, colour switch, fill, black/white.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one RGBA pixel per request; s_tlast marks the region's last
//   pixel and s_tuser is the black/white pass (0 measure, 1 classify).
//   m_* returns the result pixel; m_tuser is the changed flag and m_tlast
//   copies the input's last mark. The measuring pass returns nothing.
//   The cfg_* port writes one register per cycle; write only while idle.
//   An accepted result is registered in the output register, or in the
//   skid entry while that is full. Throughput: one pixel per cycle while
//   s_tready is high. The output register plus a one-entry skid stage
//   let input take one more pixel after m_tready drops; then s_tready
//   falls until the result drains. After the last measuring pixel, input
//   stalls while an 8-step restoring divider forms the mean bit by bit.
//   Reset (aresetn low, synchronous) clears config to 0, the grey sum, the
//   pixel count, the mean and all valid flags; no result is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pixel_point_op_engine_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [ppoe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ppoe_pkg::PIX_W-1:0]        cfg_wdata,
    // pixel input
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ppoe_pkg::DATA_W-1:0]       s_tdata,  // in_red, in_green, in_blue, in_alpha
    input  wire logic                              s_tuser,  // pass_index
    input  wire logic                              s_tlast,  // last_pixel
    // result output
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [ppoe_pkg::DATA_W-1:0]            m_tdata,  // out_red, out_green, out_blue, out_alpha
    output logic                                   m_tuser,  // changed
    output logic                                   m_tlast   // out_last
);
    import ppoe_pkg::*;

    ppoe_cmd_t        cmd;
    ppoe_status_t     status;
    logic             div_done;
    logic [Q_W-1:0]   div_quot;
    logic [SUM_W-1:0] div_dividend;
    logic [CNT_W-1:0] div_divisor;

    // handshake sequencing and mean-division wait
    ppoe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .div_done (div_done),
        .cmd      (cmd)
    );

    // one quotient bit per cycle; started on the last measuring pixel
    ppoe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // pixel math, accumulators and result registers
    ppoe_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .cmd          (cmd),
        .div_done     (div_done),
        .div_quot     (div_quot),
        .status       (status),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule

`default_nettype wire
